// ----- rtl/lpg_pkg.sv -----
package lpg_pkg;

    // Widest coordinate the block carries; the payload structs use it.
    localparam int LPG_COORD_BITS = 6;

    typedef struct packed {
        logic [LPG_COORD_BITS-1:0] start_x;
        logic [LPG_COORD_BITS-1:0] start_y;
        logic [LPG_COORD_BITS-1:0] end_x;
        logic [LPG_COORD_BITS-1:0] end_y;
    } t_lpg_in;

    typedef struct packed {
        logic [LPG_COORD_BITS-1:0] point_x;
        logic [LPG_COORD_BITS-1:0] point_y;
        logic                      last;
    } t_lpg_out;

    // Axis orientation of a line, handed from the span unit to the sequencer.
    typedef struct packed {
        logic x_major;
        logic x_up;
        logic y_up;
    } t_lpg_dir;

    typedef enum logic {
        LPG_IDLE,
        LPG_RUN
    } t_lpg_state;

endpackage

// ----- rtl/lpg_span.sv -----
module lpg_span #(
    parameter int COORD_BITS = lpg_pkg::LPG_COORD_BITS
) (
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    output lpg_pkg::t_lpg_dir     o_dir,
    output logic [COORD_BITS-1:0] o_big,
    output logic [COORD_BITS-1:0] o_small
);

    logic                  x_up;
    logic                  y_up;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic                  x_major;

    always_comb begin
        x_up    = i_end_x > i_start_x;
        y_up    = i_end_y > i_start_y;
        dx      = x_up ? (i_end_x - i_start_x) : (i_start_x - i_end_x);
        dy      = y_up ? (i_end_y - i_start_y) : (i_start_y - i_end_y);
        // Ties go to x, which makes equal spans a plain diagonal.
        x_major = dx >= dy;

        o_dir.x_major = x_major;
        o_dir.x_up    = x_up;
        o_dir.y_up    = y_up;
        o_big         = x_major ? dx : dy;
        o_small       = x_major ? dy : dx;
    end

endmodule

// ----- rtl/line_point_generator.sv -----
// Line point generator. A transaction on the input side carries a start point
// and an end point; the block answers with every grid point on the line
// between them, end point first and start point last, the last point marked
// by o_point.last. With D the larger of the two axis spans, a line yields D+1
// points, one per clock cycle, each shown on o_point for exactly one cycle
// under o_point_valid. The receiver cannot stall the stream, so it must take
// every point in the cycle it appears. An input transaction is taken when
// start is high while busy is low; busy stays high until the final point has
// been registered, so no new line is taken while one is still in flight.
// The point rate is set by one shared subtract-and-compare unit that
// updates the minor-axis remainder each cycle.
module line_point_generator #(
    parameter int COORD_BITS = lpg_pkg::LPG_COORD_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  lpg_pkg::t_lpg_in  i_item,
    output logic              busy,
    output logic              o_point_valid,
    output lpg_pkg::t_lpg_out o_point
);

    localparam logic [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);

    // Span and direction of the incoming line.
    lpg_pkg::t_lpg_dir     span_dir;
    logic [COORD_BITS-1:0] span_big;
    logic [COORD_BITS-1:0] span_small;

    lpg_span #(
        .COORD_BITS(COORD_BITS)
    ) u_span (
        .i_start_x(i_item.start_x[COORD_BITS-1:0]),
        .i_start_y(i_item.start_y[COORD_BITS-1:0]),
        .i_end_x  (i_item.end_x[COORD_BITS-1:0]),
        .i_end_y  (i_item.end_y[COORD_BITS-1:0]),
        .o_dir    (span_dir),
        .o_big    (span_big),
        .o_small  (span_small)
    );

    // Sequencer and walk state.
    lpg_pkg::t_lpg_state   r_state, n_state;
    lpg_pkg::t_lpg_dir     r_dir, n_dir;
    logic [COORD_BITS-1:0] r_big, n_big;
    logic [COORD_BITS-1:0] r_small, n_small;
    logic [COORD_BITS-1:0] r_step, n_step;     // major-axis steps still to go
    logic [COORD_BITS-1:0] r_rem, n_rem;       // remainder of small*step / big
    logic [COORD_BITS-1:0] r_cur_x, n_cur_x;
    logic [COORD_BITS-1:0] r_cur_y, n_cur_y;

    // Output register.
    logic                  r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0] r_out_x, n_out_x;
    logic [COORD_BITS-1:0] r_out_y, n_out_y;
    logic                  r_out_last, n_out_last;

    // Shared remainder unit: one subtract, its borrow, and the fold-back add.
    logic [COORD_BITS:0]   rem_diff;
    logic                  minor_step;
    logic                  move_x;
    logic                  move_y;
    logic                  accept;

    assign accept     = start && (r_state == lpg_pkg::LPG_IDLE);
    assign rem_diff   = {1'b0, r_rem} - {1'b0, r_small};
    assign minor_step = rem_diff[COORD_BITS];
    assign move_x     = r_dir.x_major || minor_step;
    assign move_y     = !r_dir.x_major || minor_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpg_pkg::LPG_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dir      <= n_dir;
        r_big      <= n_big;
        r_small    <= n_small;
        r_step     <= n_step;
        r_rem      <= n_rem;
        r_cur_x    <= n_cur_x;
        r_cur_y    <= n_cur_y;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_dir       = r_dir;
        n_big       = r_big;
        n_small     = r_small;
        n_step      = r_step;
        n_rem       = r_rem;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_out_valid = 1'b0;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_last  = r_out_last;

        case (r_state)
            lpg_pkg::LPG_IDLE: begin
                if (accept) begin
                    // Begin at the end point: step = big, minor offset = small,
                    // remainder zero.
                    n_state = lpg_pkg::LPG_RUN;
                    n_dir   = span_dir;
                    n_big   = span_big;
                    n_small = span_small;
                    n_step  = span_big;
                    n_rem   = '0;
                    n_cur_x = i_item.end_x[COORD_BITS-1:0];
                    n_cur_y = i_item.end_y[COORD_BITS-1:0];
                end
            end
            lpg_pkg::LPG_RUN: begin
                // Emit the current point.
                n_out_valid = 1'b1;
                n_out_x     = r_cur_x;
                n_out_y     = r_cur_y;
                n_out_last  = (r_step == '0);

                if (r_step == '0) begin
                    n_state = lpg_pkg::LPG_IDLE;
                end else begin
                    // Advance one major step toward the start point; drop the
                    // minor quotient by one whenever the remainder borrows.
                    n_step = r_step - COORD_ONE;
                    n_rem  = minor_step ? (rem_diff[COORD_BITS-1:0] + r_big)
                                        : rem_diff[COORD_BITS-1:0];
                    if (move_x) begin
                        n_cur_x = r_dir.x_up ? (r_cur_x - COORD_ONE)
                                             : (r_cur_x + COORD_ONE);
                    end
                    if (move_y) begin
                        n_cur_y = r_dir.y_up ? (r_cur_y - COORD_ONE)
                                             : (r_cur_y + COORD_ONE);
                    end
                end
            end
            default: begin
                n_state = lpg_pkg::LPG_IDLE;
            end
        endcase
    end

    assign busy          = (r_state != lpg_pkg::LPG_IDLE);
    assign o_point_valid = r_out_valid;

    // Widen the coordinates to the payload width.
    always_comb begin
        o_point         = '0;
        o_point.point_x = lpg_pkg::LPG_COORD_BITS'(r_out_x);
        o_point.point_y = lpg_pkg::LPG_COORD_BITS'(r_out_y);
        o_point.last    = r_out_last;
    end

endmodule
